>>> design/spdm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse dot product merge unit: shared package
// Command format, kind codes and default sizes used by the front end,
// the command queue and the merge back end.
// ----------------------------------------------------------------------------
`default_nettype none

package spdm_pkg;

  // Widths of the item and result fields at the block boundary.
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 16;
  localparam int VALUE_W = 32;
  localparam int DOT_W   = 64;
  localparam int MATCH_W = 9;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_ENTRIES = 256;
  localparam int DEF_INDEX_BITS  = 16;

  // Depth of the queue between front end and back end.
  localparam int QUEUE_DEPTH = 4;

  // Kind codes of an input item.
  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // Operation carried through the queue.
  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_COMPUTE
  } cmd_op_t;

  // One classified command.
  typedef struct packed {
    cmd_op_t                     op;
    logic [INDEX_W-1:0]          index;
    logic signed [VALUE_W-1:0]   value;
  } cmd_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

>>> design/spdm_front.sv
// ----------------------------------------------------------------------------
// Sparse dot product merge unit: front end
// Accepts input items, masks the index, decodes the kind and pushes one
// command per useful item into the queue. Unused kinds are accepted and
// dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module spdm_front
  import spdm_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [KIND_W-1:0]           kind,
  input  wire logic [INDEX_W-1:0]          index,
  input  wire logic signed [VALUE_W-1:0]   value,
  input  wire queue_status_t               q_status,
  output logic                             push,
  output cmd_t                             push_cmd
);

  // Only the low INDEX_BITS bits of the index take part.
  localparam int IW = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  localparam logic [INDEX_W:0] IDX_MASK_WIDE = (({{INDEX_W{1'b0}}, 1'b1}) << IW) - 1'b1;
  localparam logic [INDEX_W-1:0] IDX_MASK = IDX_MASK_WIDE[INDEX_W-1:0];

  logic    known_kind;
  cmd_op_t op_dec;

  // Decode the kind field.
  always_comb begin
    known_kind = 1'b1;
    op_dec     = OP_LOAD_A;
    unique case (kind)
      KIND_LOAD_A:  op_dec = OP_LOAD_A;
      KIND_LOAD_B:  op_dec = OP_LOAD_B;
      KIND_COMPUTE: op_dec = OP_COMPUTE;
      default:      known_kind = 1'b0;
    endcase
  end

  // The front end holds off only while the queue has no room.
  assign in_stall = q_status.full;

  assign push           = in_valid && !q_status.full && known_kind && !rst;
  assign push_cmd.op    = op_dec;
  assign push_cmd.index = index & IDX_MASK;
  assign push_cmd.value = value;

endmodule

`default_nettype wire

>>> design/spdm_queue.sv
// ----------------------------------------------------------------------------
// Sparse dot product merge unit: command queue
// A short first-in first-out queue that decouples the front end from the
// merge back end, so loads keep arriving while a compute runs.
// ----------------------------------------------------------------------------
`default_nettype none

module spdm_queue
  import spdm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output cmd_t       head,
  output queue_status_t status
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign status.empty = (fill == '0);
  assign status.full  = (fill == FULL_COUNT);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!do_push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> design/spdm_back.sv
// ----------------------------------------------------------------------------
// Sparse dot product merge unit: merge back end
// Holds both entry lists in memories, appends loads with order and capacity
// checks, and on compute walks both lists in step, multiplying matched
// values into a saturating Q32.32 accumulator. Drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spdm_back
  import spdm_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire queue_status_t              q_status,
  input  wire cmd_t                       head,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [DOT_W-1:0]         dot_value,
  output logic [MATCH_W-1:0]              match_count,
  output logic                            saturated,
  output logic                            order_error,
  output logic                            capacity_error
);

  localparam int IW = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int MW = (CW > MATCH_W) ? CW : MATCH_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);
  localparam logic signed [DOT_W-1:0] ACC_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] ACC_MIN = {1'b1, {(DOT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Entry memories of both lists.
  logic [IW-1:0]              a_idx_mem [MAX_ENTRIES];
  logic signed [VALUE_W-1:0]  a_val_mem [MAX_ENTRIES];
  logic [IW-1:0]              b_idx_mem [MAX_ENTRIES];
  logic signed [VALUE_W-1:0]  b_val_mem [MAX_ENTRIES];
  logic [IW-1:0]              rd_a_idx;
  logic signed [VALUE_W-1:0]  rd_a_val;
  logic [IW-1:0]              rd_b_idx;
  logic signed [VALUE_W-1:0]  rd_b_val;

  state_t                     state;
  logic [CW-1:0]              count_a;
  logic [CW-1:0]              count_b;
  logic                       have_last_a;
  logic                       have_last_b;
  logic [IW-1:0]              last_a;
  logic [IW-1:0]              last_b;
  logic                       err_order;
  logic                       err_capacity;
  logic [CW-1:0]              ia;
  logic [CW-1:0]              ib;
  logic [MW-1:0]              match_total;
  logic signed [DOT_W-1:0]    acc;
  logic                       acc_sat;
  logic signed [DOT_W-1:0]    prod;
  logic                       prod_valid;

  logic [IW-1:0]              cmd_idx;
  logic                       load_a;
  logic                       load_b;
  logic                       start_compute;
  logic                       full_a;
  logic                       full_b;
  logic                       order_bad_a;
  logic                       order_bad_b;
  logic                       write_a;
  logic                       write_b;
  logic                       hit;
  logic [CW-1:0]              ia_next;
  logic [CW-1:0]              ib_next;
  logic                       more;
  logic signed [DOT_W:0]      sum_wide;
  logic signed [DOT_W-1:0]    acc_add;
  logic                       add_ovf;
  logic                       out_free;

  // Command decode and load checks.
  assign pop           = (state == ST_IDLE) && !q_status.empty;
  assign cmd_idx       = head.index[IW-1:0];
  assign load_a        = pop && (head.op == OP_LOAD_A);
  assign load_b        = pop && (head.op == OP_LOAD_B);
  assign start_compute = pop && (head.op == OP_COMPUTE);
  assign full_a        = (count_a >= FULL_COUNT);
  assign full_b        = (count_b >= FULL_COUNT);
  assign order_bad_a   = have_last_a && (cmd_idx <= last_a);
  assign order_bad_b   = have_last_b && (cmd_idx <= last_b);
  assign write_a       = load_a && !full_a && !order_bad_a;
  assign write_b       = load_b && !full_b && !order_bad_b;

  // Merge step: compare the two heads and advance the lower one, or both on a match.
  always_comb begin
    hit     = 1'b0;
    ia_next = ia;
    ib_next = ib;
    if (rd_a_idx == rd_b_idx) begin
      hit     = 1'b1;
      ia_next = ia + 1'b1;
      ib_next = ib + 1'b1;
    end else if (rd_a_idx < rd_b_idx) begin
      ia_next = ia + 1'b1;
    end else begin
      ib_next = ib + 1'b1;
    end
  end
  assign more = (ia_next < count_a) && (ib_next < count_b);

  // Saturating accumulate of the registered product.
  assign sum_wide = {acc[DOT_W-1], acc} + {prod[DOT_W-1], prod};
  assign add_ovf  = (sum_wide[DOT_W] != sum_wide[DOT_W-1]);
  assign acc_add  = add_ovf ? (sum_wide[DOT_W] ? ACC_MIN : ACC_MAX) : sum_wide[DOT_W-1:0];

  assign out_free = !out_valid || !out_stall;

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (write_a) begin
      a_idx_mem[count_a[AW-1:0]] <= cmd_idx;
      a_val_mem[count_a[AW-1:0]] <= head.value;
    end
    if (write_b) begin
      b_idx_mem[count_b[AW-1:0]] <= cmd_idx;
      b_val_mem[count_b[AW-1:0]] <= head.value;
    end
    rd_a_idx <= a_idx_mem[ia[AW-1:0]];
    rd_a_val <= a_val_mem[ia[AW-1:0]];
    rd_b_idx <= b_idx_mem[ib[AW-1:0]];
    rd_b_val <= b_val_mem[ib[AW-1:0]];
  end

  // Product register after the multiplier.
  always_ff @(posedge clk) begin
    if (state == ST_CMP && hit) begin
      prod <= DOT_W'(rd_a_val * rd_b_val);
    end
  end

  // Sequencer, list bookkeeping, accumulator and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count_a      <= '0;
      count_b      <= '0;
      have_last_a  <= 1'b0;
      have_last_b  <= 1'b0;
      err_order    <= 1'b0;
      err_capacity <= 1'b0;
      ia           <= '0;
      ib           <= '0;
      match_total  <= '0;
      acc_sat      <= 1'b0;
      prod_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // The result register loads in the done state and empties when taken.
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      prod_valid <= (state == ST_CMP) && hit;
      if (prod_valid) begin
        acc <= acc_add;
        if (add_ovf) begin
          acc_sat <= 1'b1;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (load_a) begin
            if (full_a) begin
              err_capacity <= 1'b1;
            end else if (order_bad_a) begin
              err_order <= 1'b1;
            end else begin
              count_a     <= count_a + 1'b1;
              have_last_a <= 1'b1;
              last_a      <= cmd_idx;
            end
          end
          if (load_b) begin
            if (full_b) begin
              err_capacity <= 1'b1;
            end else if (order_bad_b) begin
              err_order <= 1'b1;
            end else begin
              count_b     <= count_b + 1'b1;
              have_last_b <= 1'b1;
              last_b      <= cmd_idx;
            end
          end
          if (start_compute) begin
            ia          <= '0;
            ib          <= '0;
            match_total <= '0;
            acc         <= '0;
            acc_sat     <= 1'b0;
            if (count_a != '0 && count_b != '0) begin
              state <= ST_READ;
            end else begin
              state <= ST_DONE;
            end
          end
        end

        ST_READ: begin
          state <= ST_CMP;
        end

        ST_CMP: begin
          ia <= ia_next;
          ib <= ib_next;
          if (hit) begin
            match_total <= match_total + 1'b1;
          end
          state <= more ? ST_READ : ST_DRAIN;
        end

        ST_DRAIN: begin
          state <= ST_DONE;
        end

        ST_DONE: begin
          if (out_free) begin
            dot_value      <= acc;
            match_count    <= match_total[MATCH_W-1:0];
            saturated      <= acc_sat;
            order_error    <= err_order;
            capacity_error <= err_capacity;
            count_a        <= '0;
            count_b        <= '0;
            have_last_a    <= 1'b0;
            have_last_b    <= 1'b0;
            err_order      <= 1'b0;
            err_capacity   <= 1'b0;
            state          <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/sparse_dot_product_merge_unit.sv
// Loads are taken from the queue while the back end is idle; items enter a 4-deep
// queue at one per cycle while it has room. A compute runs at most count_a +
// count_b - 1 merge steps (read, then compare), then drain and done; each list
// memory has one registered read port. With an empty list, compute goes to done.
// Synchronous reset empties both lists and the queue and clears the error flags;
// the list memories are not cleared.
// ----------------------------------------------------------------------------
// Sparse dot product merge unit: top level
// Front end, command queue and merge back end for the dot product of two
// sparse vectors loaded as ascending (index, value) lists.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_dot_product_merge_unit
  import spdm_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [KIND_W-1:0]          kind,
  input  wire logic [INDEX_W-1:0]         index,
  input  wire logic signed [VALUE_W-1:0]  value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [DOT_W-1:0]         dot_value,
  output logic [MATCH_W-1:0]              match_count,
  output logic                            saturated,
  output logic                            order_error,
  output logic                            capacity_error
);

  queue_status_t q_status;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;

  // Accept and classify items.
  spdm_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .index    (index),
    .value    (value),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decoupling queue.
  spdm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Lists, merge walk and result.
  spdm_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .INDEX_BITS  (INDEX_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .dot_value      (dot_value),
    .match_count    (match_count),
    .saturated      (saturated),
    .order_error    (order_error),
    .capacity_error (capacity_error)
  );

endmodule

`default_nettype wire
